// ===== hdl/rpn_stack_calculator_core_defines.svh =====
// rpn stack calculator assertion macros
`ifndef RPN_STACK_CALCULATOR_CORE_DEFINES_SVH
`define RPN_STACK_CALCULATOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define RPN_ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("%m failed");
`define RPN_ASSERT_NEXT(label, clk, rst, cond, nxt) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error("%m failed");
`else
`define RPN_ASSERT_CLK(label, clk, rst, prop)
`define RPN_ASSERT_NEXT(label, clk, rst, cond, nxt)
`endif
`endif

// ===== hdl/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg
// shared types and codes of the rpn stack calculator
// ----------------------------------------------------------------------------
`default_nettype none
package rpn_pkg;
  localparam logic [3:0] CMD_PUSH = 4'd0;
  localparam logic [3:0] CMD_PEEK = 4'd1;
  localparam logic [3:0] CMD_ADD  = 4'd2;
  localparam logic [3:0] CMD_SUB  = 4'd3;
  localparam logic [3:0] CMD_MUL  = 4'd4;
  localparam logic [3:0] CMD_DIV  = 4'd5;
  localparam logic [3:0] CMD_SUM  = 4'd6;
  localparam logic [3:0] CMD_AVG  = 4'd7;
  localparam logic [3:0] CMD_SWAP = 4'd8;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_ONE     = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_DIVZERO = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_EXEC, S_MULW, S_DIVW, S_SUMRD, S_SUMACC,
    S_WRB, S_WRA, S_TOPRD, S_TOPW, S_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== hdl/rpn_div.sv =====
// ----------------------------------------------------------------------------
// rpn_div
// signed restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
`default_nettype none
module rpn_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);
  logic [63:0] num;
  logic [63:0] den;
  logic [64:0] rem;
  logic [6:0]  cnt;
  logic        neg;
  logic        run;
  logic [64:0] trial;

  assign trial = {rem[63:0], num[63]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 7'd0;
        rem <= '0;
        neg <= dividend[63] ^ divisor[63];
        num <= dividend[63] ? -dividend : dividend;
        den <= divisor[63] ? -divisor : divisor;
      end else if (run) begin
        if (trial[64]) begin
          rem <= {rem[63:0], num[63]};
          num <= {num[62:0], 1'b0};
        end else begin
          rem <= trial;
          num <= {num[62:0], 1'b1};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -num : num;
endmodule
`default_nettype wire

// ===== hdl/rpn_stack_calculator_core.sv =====
// rpn stack calculator: stack of q16.16 values in a one-port synchronous memory
// an empty or full stack, one entry for a two-operand command and division by 0
// set their status codes; sum and average fold all n entries into a single entry
// one command at a time, busy until the result beat, which is shown for one cycle
// synchronous active-high reset empties the stack; memory contents are undefined
`default_nettype none
`include "rpn_stack_calculator_core_defines.svh"
module rpn_stack_calculator_core #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [3:0]         command,
  input  wire logic signed [31:0] operand,
  output logic                    busy,
  output logic                    done,
  output logic signed [31:0]      top_value,
  output logic [2:0]              status,
  output logic [4:0]              depth
);
  import rpn_pkg::*;
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic signed [31:0] mem [STACK_DEPTH];
  logic               we;
  logic [AW-1:0]      addr;
  logic signed [31:0] wdata;
  logic signed [31:0] rdata;

  state_t state, state_next;
  logic [CW-1:0] count;
  logic [3:0]    cmd;
  logic signed [31:0] opnd, p, q;
  logic [CW-1:0] idx;
  logic signed [63:0] acc;
  logic signed [63:0] prod;
  logic [2:0] st, st_next;
  logic       div_start, div_done;
  logic [63:0] div_num, div_den, quo;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

  rpn_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num),
    .divisor(div_den), .done(div_done), .quotient(quo)
  );

  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic signed [63:0] mulr;
  assign mulr = (prod + 64'sd32768) >>> 16;

  always_comb begin
    state_next = state;
    st_next = st;
    we = 1'b0;
    addr = '0;
    wdata = '0;
    div_start = 1'b0;
    div_num = acc;
    div_den = 64'(count);
    unique case (state)
      S_IDLE: if (start) begin
        st_next = ST_OK;
        state_next = S_DONE;
        priority case (command)
          CMD_PUSH: if (count >= CW'(STACK_DEPTH)) st_next = ST_FULL;
            else state_next = S_WRB;
          CMD_PEEK: if (count == '0) st_next = ST_EMPTY; else state_next = S_TOPRD;
          CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_SWAP:
            if (count == '0) st_next = ST_EMPTY;
            else if (count == CW'(1)) begin st_next = ST_ONE; state_next = S_TOPRD; end
            else state_next = S_RD1;
          CMD_SUM, CMD_AVG: if (count == '0) st_next = ST_EMPTY; else state_next = S_SUMRD;
          default: if (count != '0) state_next = S_TOPRD;
        endcase
      end
      S_RD1: begin
        addr = AW'(count - CW'(1));
        state_next = S_RD2;
      end
      S_RD2: begin
        addr = AW'(count - CW'(2));
        state_next = S_EXEC;
      end
      S_EXEC: state_next = (cmd == CMD_MUL) ? S_MULW : S_WRB;
      S_MULW: state_next = S_WRB;
      S_DIVW: if (div_done) state_next = S_WRB;
      S_SUMRD: begin
        addr = AW'(idx);
        state_next = S_SUMACC;
      end
      S_SUMACC: state_next = S_SUMACC;
      S_WRB: begin
        state_next = S_TOPRD;
      end
      S_WRA: state_next = S_TOPRD;
      S_TOPRD: begin
        addr = AW'(count - CW'(1));
        state_next = S_TOPW;
      end
      S_TOPW: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    // memory writes, end of the sum loop and divider start
    if (state == S_WRB) begin
      we = 1'b1;
      unique case (cmd)
        CMD_PUSH: begin addr = AW'(count - CW'(1)); wdata = opnd; end
        CMD_SWAP: begin addr = AW'(count - CW'(1)); wdata = q; end
        CMD_SUM, CMD_AVG: begin addr = '0; wdata = sat(acc); end
        CMD_ADD: begin addr = AW'(count - CW'(2)); wdata = sat(64'(q) + 64'(p)); end
        CMD_SUB: begin addr = AW'(count - CW'(2)); wdata = sat(64'(q) - 64'(p)); end
        CMD_MUL: begin addr = AW'(count - CW'(2)); wdata = sat(mulr); end
        CMD_DIV: begin addr = AW'(count - CW'(2)); wdata = sat(quo); end
        default: we = 1'b0;
      endcase
      if (cmd == CMD_SWAP) state_next = S_WRA;
    end
    if (state == S_WRA) begin
      we = 1'b1;
      addr = AW'(count - CW'(2));
      wdata = p;
    end
    if (state == S_SUMACC) begin
      if (CW'(idx + CW'(1)) == count) begin
        state_next = (cmd == CMD_AVG) ? S_DIVW : S_WRB;
        div_start = (cmd == CMD_AVG);
        div_num = acc + 64'(rdata);
      end else begin
        state_next = S_SUMRD;
      end
    end
    if (state == S_EXEC && cmd == CMD_DIV) begin
      if (p == '0) begin
        st_next = ST_DIVZERO;
        state_next = S_TOPRD;
      end else begin
        state_next = S_DIVW;
        div_start = 1'b1;
        div_num = {{16{rdata[31]}}, rdata, 16'd0};
        div_den = 64'(p);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      st <= st_next;
      done <= (state == S_DONE);
      if (state == S_IDLE && start) begin
        cmd <= command;
        opnd <= operand;
        idx <= '0;
        acc <= '0;
        if (command == CMD_PUSH && count < CW'(STACK_DEPTH)) count <= count + CW'(1);
      end
      if (state == S_RD2) p <= rdata;
      if (state == S_EXEC) begin
        q <= rdata;
        prod <= 64'(p) * 64'(rdata);
      end
      if (state == S_SUMACC) begin
        acc <= acc + 64'(rdata);
        idx <= idx + CW'(1);
      end
      if (state == S_DIVW && div_done) acc <= quo;
      if (state == S_WRB) begin
        if (cmd == CMD_SUM || cmd == CMD_AVG) count <= CW'(1);
        else if (cmd != CMD_PUSH && cmd != CMD_SWAP) count <= count - CW'(1);
      end
      if (state == S_TOPW) top_value <= rdata;
      if (state == S_DONE) begin
        status <= st;
        depth <= 5'(count);
        if (count == '0) top_value <= '0;
      end
      if (state == S_IDLE && start && count == '0) top_value <= '0;
    end
  end

  assign busy = (state != S_IDLE);

  `RPN_ASSERT_CLK(a_count_range, clk, rst, count <= CW'(STACK_DEPTH))
  `RPN_ASSERT_NEXT(a_done_after_last, clk, rst, state == S_DONE, done)
  `RPN_ASSERT_CLK(a_done_idle, clk, rst, !done || !busy)
endmodule
`default_nettype wire
